// ===== rtl/core/owtr_pkg.sv =====
package owtr_pkg;

    // Width of the tick counter; durations above 2**TIMER_BITS ticks clip there.
    localparam int TIMER_BITS = 10;
    localparam int DUR_W      = 10;
    localparam int POLL_W     = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int FAULT_W    = 2;
    localparam int TEMP_W     = 16;
    localparam int CMP_W      = (TIMER_BITS + 1 > DUR_W) ? TIMER_BITS + 1 : DUR_W;

    localparam logic [CMP_W-1:0] TIMER_SPAN = CMP_W'(1) << TIMER_BITS;

    localparam logic [7:0] CMD_ALL_DEVICES = 8'hCC;
    localparam logic [7:0] CMD_READ_PAD    = 8'hBE;
    localparam logic [7:0] CMD_CONVERT     = 8'h44;

    localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_PRESENCE = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_NO_RISE  = 2'd2;

    typedef struct packed {
        logic                  hit;
        logic [TIMER_BITS-1:0] tick;
    } timer_step_t;

    // Command byte sent by each write step of the sequence.
    function automatic logic [7:0] step_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        unique case (step)
            3'd1:    cmd = CMD_ALL_DEVICES;
            3'd2:    cmd = CMD_READ_PAD;
            3'd6:    cmd = CMD_ALL_DEVICES;
            3'd7:    cmd = CMD_CONVERT;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

    // One tick of a wait: zero length acts as one tick, long ones clip to the span.
    function automatic timer_step_t timer_next(input logic [TIMER_BITS-1:0] tick,
                                               input logic [DUR_W-1:0] dur);
        logic [CMP_W-1:0] d;
        logic [CMP_W-1:0] n;
        timer_step_t      r;
        d = (dur == '0) ? CMP_W'(1) : CMP_W'(dur);
        if (d > TIMER_SPAN)
        begin
            d = TIMER_SPAN;
        end
        n = CMP_W'(tick) + CMP_W'(1);
        r.hit  = (n >= d);
        r.tick = r.hit ? '0 : n[TIMER_BITS-1:0];
        return r;
    endfunction

    // raw * 10 / 16, truncated toward zero.
    function automatic logic [TEMP_W-1:0] tenths(input logic [15:0] raw);
        logic signed [19:0] p;
        p = $signed({{4{raw[15]}}, raw}) * 20'sd10;
        if (p < 0)
        begin
            p = p + 20'sd15;
        end
        return p[19:4];
    endfunction

endpackage

// ===== rtl/core/owtr_in_if.sv =====
interface owtr_in_if;
    logic valid;
    logic ready;
    logic start_request;
    logic line_in;

    modport source (output valid, output start_request, output line_in, input ready);
    modport sink   (input valid, input start_request, input line_in, output ready);
endinterface

// ===== rtl/core/owtr_out_if.sv =====
interface owtr_out_if
    import owtr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               line_pull_low;
    logic               busy_res;
    logic               done_res;
    logic [FAULT_W-1:0] fault;
    logic [TEMP_W-1:0]  temperature_tenths;

    modport source (output valid, output line_pull_low, output busy_res, output done_res,
                    output fault, output temperature_tenths, input ready);
    modport sink   (input valid, input line_pull_low, input busy_res, input done_res,
                    input fault, input temperature_tenths, output ready);
endinterface

// ===== rtl/core/one_wire_temperature_reader.sv =====
// Channel  | Dir | Word contents
// ---------+-----+--------------------------------------------------------------
// in_ch    | in  | start_request, line_in (one microsecond tick of the bus)
// out_ch   | out | line_pull_low, busy_res, done_res, fault, temperature_tenths
// cfg      | in  | cfg_we / cfg_index / cfg_data, seven timing registers
//
// One input word gives one output word; a word is taken every clock cycle unless out_ch stalls a full output register.
// The whole tick step (timer, phase, shifter) is one pass of logic between
// the state registers and the output word register.
// The output register holds its word while out_ch is stalled; in_ch.ready
// stays high whenever that register is empty or being drained this cycle.
// Asynchronous active-low reset returns to idle with default timings.
module one_wire_temperature_reader
    import owtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    owtr_in_if.sink               in_ch,
    owtr_out_if.source            out_ch
);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_DATA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_RECOVER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;

    // phase codes
    localparam logic [4:0] PH_IDLE        = 5'd0;
    localparam logic [4:0] PH_RST_LOW     = 5'd1;
    localparam logic [4:0] PH_PRES_WAIT   = 5'd2;
    localparam logic [4:0] PH_RISE_WAIT   = 5'd3;
    localparam logic [4:0] PH_SETTLE_OK   = 5'd4;
    localparam logic [4:0] PH_SETTLE_FAIL = 5'd5;
    localparam logic [4:0] PH_SLOT_LOW    = 5'd6;
    localparam logic [4:0] PH_SLOT_MID    = 5'd7;
    localparam logic [4:0] PH_SLOT_TAIL   = 5'd8;

    // timing registers
    logic [DUR_W-1:0]  reset_low_reg;
    logic [DUR_W-1:0]  pres_wait_reg;
    logic [POLL_W-1:0] poll_limit_reg;
    logic [DUR_W-1:0]  slot_start_reg;
    logic [DUR_W-1:0]  slot_data_reg;
    logic [DUR_W-1:0]  slot_recover_reg;
    logic [DUR_W-1:0]  read_sample_reg;

    // transaction state
    logic [4:0]            phase_reg,   phase_next;
    logic [TIMER_BITS-1:0] tick_reg,    tick_next;
    logic [POLL_W-1:0]     poll_reg,    poll_next;
    logic [2:0]            bit_reg,     bit_next;
    logic [7:0]            shift_reg,   shift_next;
    logic [15:0]           raw_reg,     raw_next;
    logic [2:0]            step_reg,    step_next;

    // output word
    logic               out_valid_reg;
    logic               pull_reg,  pull_next;
    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic [TEMP_W-1:0]  temp_reg,  temp_next;

    logic              accept;
    logic              is_read;
    logic              go_step;
    logic [2:0]        go_value;
    logic              ending;
    logic              timed;
    logic [DUR_W-1:0]  dur;
    timer_step_t       tstep;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg    <= DUR_W'(550);
            pres_wait_reg    <= DUR_W'(50);
            poll_limit_reg   <= POLL_W'(255);
            slot_start_reg   <= DUR_W'(10);
            slot_data_reg    <= DUR_W'(60);
            slot_recover_reg <= DUR_W'(10);
            read_sample_reg  <= DUR_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESET_LOW:    reset_low_reg    <= cfg_data;
                REG_PRES_WAIT:    pres_wait_reg    <= cfg_data;
                REG_POLL_LIMIT:   poll_limit_reg   <= cfg_data[POLL_W-1:0];
                REG_SLOT_START:   slot_start_reg   <= cfg_data;
                REG_SLOT_DATA:    slot_data_reg    <= cfg_data;
                REG_SLOT_RECOVER: slot_recover_reg <= cfg_data;
                REG_READ_SAMPLE:  read_sample_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // One tick of the bus master.
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        poll_next  = poll_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        raw_next   = raw_reg;
        step_next  = step_reg;
        pull_next  = 1'b0;
        busy_next  = 1'b0;
        fault_next = FAULT_NONE;
        temp_next  = '0;
        go_step    = 1'b0;
        go_value   = 3'd0;
        ending     = 1'b0;

        // start tick is already the first reset-low tick
        if (phase_reg == PH_IDLE && in_ch.start_request)
        begin
            step_next  = 3'd0;
            tick_next  = '0;
            bit_next   = 3'd0;
            phase_next = PH_RST_LOW;
        end
        busy_next = (phase_next != PH_IDLE);
        is_read   = (step_next == 3'd3) || (step_next == 3'd4);

        // duration of the wait running in this phase
        timed = 1'b1;
        unique case (phase_next)
            PH_RST_LOW:     dur = reset_low_reg;
            PH_PRES_WAIT,
            PH_RISE_WAIT,
            PH_SETTLE_OK,
            PH_SETTLE_FAIL: dur = pres_wait_reg;
            PH_SLOT_LOW:    dur = slot_start_reg;
            PH_SLOT_MID:    dur = is_read ? read_sample_reg : slot_data_reg;
            PH_SLOT_TAIL:   dur = is_read ? slot_data_reg : slot_recover_reg;
            default:
            begin
                dur   = '0;
                timed = 1'b0;
            end
        endcase
        tstep = timer_next(tick_next, dur);
        if (timed)
        begin
            tick_next = tstep.tick;
        end

        unique case (phase_next)
            PH_IDLE: ;
            PH_RST_LOW:
            begin
                pull_next = 1'b1;
                if (tstep.hit)
                begin
                    phase_next = PH_PRES_WAIT;
                end
            end
            PH_PRES_WAIT:
            begin
                if (tstep.hit)
                begin
                    if (in_ch.line_in)
                    begin
                        ending     = 1'b1;
                        fault_next = FAULT_PRESENCE;
                    end
                    else
                    begin
                        poll_next  = '0;
                        phase_next = PH_RISE_WAIT;
                    end
                end
            end
            PH_RISE_WAIT:
            begin
                if (tstep.hit)
                begin
                    poll_next = poll_reg + POLL_W'(1);
                    if (poll_next >= poll_limit_reg)
                    begin
                        phase_next = PH_SETTLE_FAIL;
                    end
                    else if (in_ch.line_in)
                    begin
                        phase_next = PH_SETTLE_OK;
                    end
                end
            end
            PH_SETTLE_OK:
            begin
                if (tstep.hit)
                begin
                    go_step  = 1'b1;
                    go_value = step_next + 3'd1;
                end
            end
            PH_SETTLE_FAIL:
            begin
                if (tstep.hit)
                begin
                    ending     = 1'b1;
                    fault_next = FAULT_NO_RISE;
                end
            end
            PH_SLOT_LOW:
            begin
                pull_next = 1'b1;
                if (tstep.hit)
                begin
                    phase_next = PH_SLOT_MID;
                end
            end
            PH_SLOT_MID:
            begin
                if (is_read)
                begin
                    if (tstep.hit)
                    begin
                        shift_next = {in_ch.line_in, shift_reg[7:1]};
                        phase_next = PH_SLOT_TAIL;
                    end
                end
                else
                begin
                    pull_next = !shift_reg[0];
                    if (tstep.hit)
                    begin
                        phase_next = PH_SLOT_TAIL;
                    end
                end
            end
            PH_SLOT_TAIL:
            begin
                if (tstep.hit)
                begin
                    if (!is_read)
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                    end
                    if (bit_reg == 3'd7)
                    begin
                        if (step_next == 3'd3)
                        begin
                            raw_next = {raw_reg[15:8], shift_next};
                        end
                        else if (step_next == 3'd4)
                        begin
                            raw_next = {shift_next, raw_reg[7:0]};
                        end
                        if (step_next == 3'd7)
                        begin
                            ending     = 1'b1;
                            fault_next = FAULT_NONE;
                            temp_next  = tenths(raw_next);
                        end
                        else
                        begin
                            go_step  = 1'b1;
                            go_value = step_next + 3'd1;
                        end
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_SLOT_LOW;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                busy_next  = 1'b0;
            end
        endcase

        // next reset or byte of the sequence
        if (go_step)
        begin
            step_next = go_value;
            tick_next = '0;
            bit_next  = 3'd0;
            if (go_value == 3'd0 || go_value == 3'd5)
            begin
                phase_next = PH_RST_LOW;
            end
            else
            begin
                shift_next = (go_value == 3'd3 || go_value == 3'd4) ? 8'h00 : step_cmd(go_value);
                phase_next = PH_SLOT_LOW;
            end
        end

        done_next = ending;
        if (ending)
        begin
            phase_next = PH_IDLE;
            step_next  = 3'd0;
            tick_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            poll_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            raw_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                poll_reg  <= poll_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                raw_reg   <= raw_next;
                step_reg  <= step_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pull_reg  <= pull_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            fault_reg <= fault_next;
            temp_reg  <= temp_next;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.line_pull_low      = pull_reg;
    assign out_ch.busy_res           = busy_reg;
    assign out_ch.done_res           = done_reg;
    assign out_ch.fault              = fault_reg;
    assign out_ch.temperature_tenths = temp_reg;

`ifndef SYNTH
    // a finished transaction is always a busy tick
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> busy_reg)
        else $error("done without busy");

    // fault code only travels with done
    a_fault_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (fault_reg != FAULT_NONE) |-> done_reg)
        else $error("fault outside done");

    // a reading is only reported by a clean finish
    a_temp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (temp_reg != '0) |-> done_reg && (fault_reg == FAULT_NONE))
        else $error("temperature without clean done");

    // after an ending tick the master is back in idle with the sequence rewound
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ending |=> (phase_reg == PH_IDLE) && (step_reg == 3'd0))
        else $error("not idle after done");

    // bus is never driven while idle
    a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !busy_reg |-> !pull_reg)
        else $error("bus driven while idle");
`endif

endmodule
